[rtl/hsl_to_rgb_converter_defines.svh]
// Assertion macros for the HSL to RGB converter.
// Used by the top level; expects signals clk and rst in the enclosing scope.
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSL2RGB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSL2RGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hsl2rgb_pkg.sv]
// Types, constants and helper functions of the HSL to RGB converter.
// Has no dependencies; the converter top level refers to it by scoped names.
package hsl2rgb_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int FIELD_W     = 9;
  localparam int BYTE_W      = 8;
  localparam int NUM_CH      = 3;
  localparam int NUM_STAGES  = 5;
  localparam int ONE_W       = FRAC_BITS + 1;
  localparam int LVL_W       = 2 * FRAC_BITS + 1;
  localparam int RAMP_W      = 6;
  localparam int SC_W        = LVL_W + RAMP_W;
  localparam int PROD_W      = SC_W + BYTE_W;
  localparam int DIV_SHIFT   = 2 * FRAC_BITS + 2;
  localparam int N_W         = PROD_W - DIV_SHIFT;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int Q_W         = N_W + RECIP_W - RECIP_SHIFT;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [ONE_W-1:0]   unit_t;
  typedef logic [LVL_W-1:0]   level_t;
  typedef logic [RAMP_W-1:0]  ramp_t;
  typedef logic [SC_W-1:0]    scaled_t;
  typedef logic [N_W-1:0]     quot_t;

  localparam unit_t ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam unit_t HALF = ONE >> 1;

  localparam field_t HUE_FULL       = 9'd360;
  localparam field_t HUE_THIRD      = 9'd120;
  localparam field_t HUE_TWO_THIRDS = 9'd240;
  localparam field_t HUE_RISE_END   = 9'd60;
  localparam field_t HUE_FALL_START = 9'd180;
  localparam ramp_t  RAMP_TOP       = 6'd60;

  localparam scaled_t SCALED_MAX = SC_W'(60) << (2 * FRAC_BITS);

  // Multiplying by RECIP and shifting right by RECIP_SHIFT divides by 15
  // exactly for every quotient operand below 4681.
  localparam logic [RECIP_W-1:0] RECIP    = 13'd4370;
  localparam byte_t              BYTE_MAX = 8'hFF;

  function automatic unit_t clamp_unit(field_t v);
    unit_t r;
    if (v > ONE) begin
      r = ONE;
    end else begin
      r = ONE_W'(v);
    end
    return r;
  endfunction

  // Position on the trapezoid in sixtieths: rises over the first sixty
  // degrees, stays high up to 180, falls back by 240 and stays low after.
  function automatic ramp_t hue_ramp(field_t d);
    ramp_t r;
    priority if (d < HUE_RISE_END) begin
      r = RAMP_W'(d);
    end else if (d < HUE_FALL_START) begin
      r = RAMP_TOP;
    end else if (d < HUE_TWO_THIRDS) begin
      r = RAMP_W'(HUE_TWO_THIRDS - d);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

[rtl/hsl_to_rgb_converter.sv]
// HSL to RGB converter: a five-stage pipeline with one color per item.
// Depends on hsl2rgb_pkg and hsl_to_rgb_converter_defines.svh.
//
//   channel  handshake             payload
//   input    hsl_valid/hsl_ready   hue_degrees, saturation, lightness
//   output   rgb_valid/rgb_ready   red, green, blue
//
// One item enters per cycle while hsl_ready is high; results leave from the last stage.
// The five register stages are the clamps and the lightness times saturation
// product, the upper and lower levels, the ramp multiply, the scale by 255,
// and the divide by 15 done as a reciprocal multiply.
// Reset clears only the stage valid bits.
// A stall holds only the stages that are full behind it, so bubbles close up.
module hsl_to_rgb_converter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  hsl_valid,
  output logic                  hsl_ready,
  input  hsl2rgb_pkg::field_t   hue_degrees,
  input  hsl2rgb_pkg::field_t   saturation,
  input  hsl2rgb_pkg::field_t   lightness,
  output logic                  rgb_valid,
  input  logic                  rgb_ready,
  output hsl2rgb_pkg::byte_t    red,
  output hsl2rgb_pkg::byte_t    green,
  output hsl2rgb_pkg::byte_t    blue
);

  `include "hsl_to_rgb_converter_defines.svh"

  localparam int W1 = hsl2rgb_pkg::LVL_W + 1;
  localparam int LS_W = 2 * hsl2rgb_pkg::ONE_W;
  localparam int QF_W = hsl2rgb_pkg::N_W + hsl2rgb_pkg::RECIP_W;

  logic [hsl2rgb_pkg::NUM_STAGES-1:0] vld;
  logic [hsl2rgb_pkg::NUM_STAGES-1:0] adv;

  hsl2rgb_pkg::field_t  hue_wrap, hue_r, hue_b;
  hsl2rgb_pkg::unit_t   l_clamp, s_clamp;
  logic [LS_W-1:0]      ls_full;

  hsl2rgb_pkg::unit_t   s0_l, s0_s;
  hsl2rgb_pkg::level_t  s0_ls;
  logic                 s0_low;
  hsl2rgb_pkg::ramp_t   s0_ramp [hsl2rgb_pkg::NUM_CH];

  logic [W1-1:0]        l_one, s_one, ls_w, v2_w, v1_w;
  hsl2rgb_pkg::level_t  v1_lvl;

  hsl2rgb_pkg::scaled_t s1_base;
  hsl2rgb_pkg::level_t  s1_span;
  hsl2rgb_pkg::ramp_t   s1_ramp [hsl2rgb_pkg::NUM_CH];

  hsl2rgb_pkg::scaled_t s2_scaled [hsl2rgb_pkg::NUM_CH];
  hsl2rgb_pkg::quot_t   s3_n [hsl2rgb_pkg::NUM_CH];
  hsl2rgb_pkg::byte_t   s4_byte [hsl2rgb_pkg::NUM_CH];

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    adv[hsl2rgb_pkg::NUM_STAGES-1] = !vld[hsl2rgb_pkg::NUM_STAGES-1] || rgb_ready;
    for (int k = hsl2rgb_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign hsl_ready = adv[0];
  assign rgb_valid = vld[hsl2rgb_pkg::NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= hsl_valid;
      end
      for (int k = 1; k < hsl2rgb_pkg::NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 0: hue wrap and channel offsets, clamps, lightness times saturation.
  always_comb begin
    hue_wrap = (hue_degrees >= hsl2rgb_pkg::HUE_FULL) ?
               hue_degrees - hsl2rgb_pkg::HUE_FULL : hue_degrees;
    hue_r = hue_wrap + hsl2rgb_pkg::HUE_THIRD;
    if (hue_r > hsl2rgb_pkg::HUE_FULL) begin
      hue_r = hue_r - hsl2rgb_pkg::HUE_FULL;
    end
    hue_b = (hue_wrap < hsl2rgb_pkg::HUE_THIRD) ?
            hue_wrap + hsl2rgb_pkg::HUE_TWO_THIRDS : hue_wrap - hsl2rgb_pkg::HUE_THIRD;
    l_clamp = hsl2rgb_pkg::clamp_unit(lightness);
    s_clamp = hsl2rgb_pkg::clamp_unit(saturation);
    ls_full = LS_W'(l_clamp) * LS_W'(s_clamp);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_l       <= l_clamp;
      s0_s       <= s_clamp;
      s0_ls      <= hsl2rgb_pkg::LVL_W'(ls_full);
      s0_low     <= l_clamp < hsl2rgb_pkg::HALF;
      s0_ramp[0] <= hsl2rgb_pkg::hue_ramp(hue_r);
      s0_ramp[1] <= hsl2rgb_pkg::hue_ramp(hue_wrap);
      s0_ramp[2] <= hsl2rgb_pkg::hue_ramp(hue_b);
    end
  end

  // Stage 1: upper and lower levels; the base is the lower level times 60.
  always_comb begin
    l_one  = W1'(s0_l) << hsl2rgb_pkg::FRAC_BITS;
    s_one  = W1'(s0_s) << hsl2rgb_pkg::FRAC_BITS;
    ls_w   = W1'(s0_ls);
    v2_w   = s0_low ? l_one + ls_w : l_one + s_one - ls_w;
    v1_w   = (l_one << 1) - v2_w;
    v1_lvl = hsl2rgb_pkg::LVL_W'(v1_w);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_base <= (hsl2rgb_pkg::SC_W'(v1_lvl) << 6) - (hsl2rgb_pkg::SC_W'(v1_lvl) << 2);
      s1_span <= hsl2rgb_pkg::LVL_W'(v2_w - v1_w);
      s1_ramp <= s0_ramp;
    end
  end

  // Stages 2 to 4 work on the three channels side by side.
  always_ff @(posedge clk) begin
    for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
      if (adv[2]) begin
        s2_scaled[c] <= s1_base + hsl2rgb_pkg::SC_W'(s1_span) * hsl2rgb_pkg::SC_W'(s1_ramp[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [hsl2rgb_pkg::PROD_W-1:0] prod;
    for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
      prod = (hsl2rgb_pkg::PROD_W'(s2_scaled[c]) << hsl2rgb_pkg::BYTE_W)
             - hsl2rgb_pkg::PROD_W'(s2_scaled[c]);
      if (adv[3]) begin
        s3_n[c] <= prod[hsl2rgb_pkg::PROD_W-1:hsl2rgb_pkg::DIV_SHIFT];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [QF_W-1:0]              q_full;
    logic [hsl2rgb_pkg::Q_W-1:0]  q;
    for (int c = 0; c < hsl2rgb_pkg::NUM_CH; c++) begin
      q_full = QF_W'(s3_n[c]) * QF_W'(hsl2rgb_pkg::RECIP);
      q = q_full[QF_W-1:hsl2rgb_pkg::RECIP_SHIFT];
      if (adv[4]) begin
        s4_byte[c] <= (q > hsl2rgb_pkg::Q_W'(hsl2rgb_pkg::BYTE_MAX)) ?
                      hsl2rgb_pkg::BYTE_MAX : hsl2rgb_pkg::BYTE_W'(q);
      end
    end
  end

  assign red   = s4_byte[0];
  assign green = s4_byte[1];
  assign blue  = s4_byte[2];

  `HSL2RGB_ASSERT_NOW(a_ready_chain, !hsl_ready,
    vld[hsl2rgb_pkg::NUM_STAGES-1] && !rgb_ready, "Input stalled while the pipeline can move.")

  `HSL2RGB_ASSERT_NEXT(a_stage2_hold, vld[2] && !adv[2],
    vld[2] && $stable(s2_scaled[0]), "A held stage lost or changed its item.")

  `HSL2RGB_ASSERT_NOW(a_scaled_range, vld[2],
    s2_scaled[0] <= hsl2rgb_pkg::SCALED_MAX && s2_scaled[2] <= hsl2rgb_pkg::SCALED_MAX,
    "Scaled channel level exceeds full scale.")

endmodule
